// File: hdl/point_in_polygon_test_macros.svh
// Assertion macros shared by the point-in-polygon RTL.
`ifndef POINT_IN_POLYGON_TEST_MACROS_SVH
`define POINT_IN_POLYGON_TEST_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PIP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pip assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PIP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pip assertion failed");

`endif

// File: hdl/pip_pkg.sv
// Package: types and constants of the point-in-polygon test.
package pip_pkg;

  localparam int COORD_W = 16;
  localparam int CNT_W   = 7;
  localparam int IDX_W   = 6;

  localparam int MIN_POLY_VERTICES = 3;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } pip_state_t;

endpackage

// File: hdl/point_in_polygon_test.sv
// Point-in-polygon test by the even-odd ray crossing rule over a vertex memory.
//
//  channel | handshake                 | payload
//  --------+---------------------------+---------------------------------------------
//  in      | start / busy              | in_command, in_vertex_index, in_coord_x/y
//  out     | out_valid (1-cycle strobe) | out_inside_res
//  cfg     | cfg_valid / cfg_ready     | cfg_vertex_count
//
//  A write request is taken whenever busy is low, and busy stays low.
//  A query over n vertices (n clamped to MAX_VERTICES) reads the single read port of the vertex
//  memory once per vertex plus once for the closing vertex, then strobes its result when the
//  last edge has passed stage 2; busy is high from acceptance until that strobe.
//  A query with fewer than three vertices strobes outside in the next cycle.
//  Synchronous active-low reset clears control and the vertex count, not the memory.
//  The receiver cannot stall: each result is shown for exactly one cycle.
`include "point_in_polygon_test_macros.svh"

module point_in_polygon_test #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // request channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_command,
  input  logic        [pip_pkg::IDX_W-1:0]     in_vertex_index,
  input  logic signed [pip_pkg::COORD_W-1:0]   in_coord_x,
  input  logic signed [pip_pkg::COORD_W-1:0]   in_coord_y,
  // result channel
  output logic                                 out_valid,
  output logic                                 out_inside_res,
  // configuration
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [pip_pkg::CNT_W-1:0]     cfg_vertex_count
);
  import pip_pkg::*;

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = AW + 1;               // holds MAX_VERTICES itself
  localparam int DW = 2 * COORD_W;          // {x, y} per entry
  localparam int PW = 2 * (COORD_W + 1);    // cross-product width

  // ---------------------------------------------------------------------------
  // Configuration: vertex count register, writable whenever offered.
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] vcount_r;
  logic [CW-1:0]    n_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      vcount_r <= cfg_vertex_count;
    end
  end

  // counts above the memory depth use the whole memory
  assign n_eff = (32'(vcount_r) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(vcount_r);

  // ---------------------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------------------
  pip_state_t state_r, state_nxt;
  logic       req_acc, req_wr, req_qry, short_poly;

  assign busy       = (state_r != ST_IDLE);
  assign req_acc    = start && !busy;
  assign req_wr     = req_acc && (in_command == CMD_WRITE)
                      && (32'(in_vertex_index) < MAX_VERTICES);
  assign req_qry    = req_acc && (in_command == CMD_QUERY);
  assign short_poly = (32'(n_eff) < MIN_POLY_VERTICES);

  // ---------------------------------------------------------------------------
  // Vertex memory: one write port (idle only), one registered read port.
  // Writes and query reads never overlap since busy blocks writes.
  // ---------------------------------------------------------------------------
  logic [DW-1:0] vmem [MAX_VERTICES];
  logic [DW-1:0] rd_data_r;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  always_ff @(posedge clk) begin
    if (req_wr) begin
      vmem[AW'(in_vertex_index)] <= {in_coord_x, in_coord_y};
    end
    if (rd_en) begin
      rd_data_r <= vmem[rd_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // Read sequencer: reads vertex n-1 first (closing edge), then 0 .. n-1.
  // ---------------------------------------------------------------------------
  logic [CW-1:0] n_r;
  logic [CW-1:0] iss_r;
  logic          rd_last;

  assign rd_en   = (state_r == ST_RUN);
  assign rd_addr = (iss_r == '0) ? AW'(n_r - CW'(1)) : AW'(iss_r - CW'(1));
  assign rd_last = (iss_r == n_r);

  // stage 1 flags (data out of memory this cycle)
  logic rd_v_r, rd_first_r, rd_last_r;
  // stage 2 flags (products registered)
  logic s2_v_r, s2_last_r;
  logic parity_r;
  logic out_valid_r, out_inside_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (req_qry && !short_poly) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (rd_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (s2_v_r && s2_last_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  logic signed [COORD_W-1:0] px_r, py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      iss_r      <= '0;
      rd_v_r     <= 1'b0;
      rd_first_r <= 1'b0;
      rd_last_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rd_v_r     <= rd_en;
      rd_first_r <= rd_en && (iss_r == '0);
      rd_last_r  <= rd_en && rd_last;
      if (req_qry) begin
        iss_r <= '0;
      end else if (rd_en) begin
        iss_r <= iss_r + CW'(1);
      end
    end
  end

  // query operands, held for the whole pass
  always_ff @(posedge clk) begin
    if (req_qry) begin
      px_r <= in_coord_x;
      py_r <= in_coord_y;
      n_r  <= n_eff;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: edge (a = current vertex, b = previous vertex), straddle and
  // cross-multiplications.
  // ---------------------------------------------------------------------------
  logic signed [COORD_W-1:0] ax, ay, bx, by;
  logic signed [COORD_W-1:0] prev_x_r, prev_y_r;
  logic signed [COORD_W:0]   dy, dxp, dxb, dyp;
  logic signed [PW-1:0]      lhs, rhs;
  logic                      straddle;

  assign ax = rd_data_r[DW-1:COORD_W];
  assign ay = rd_data_r[COORD_W-1:0];
  assign bx = prev_x_r;
  assign by = prev_y_r;

  assign straddle = (ay > py_r) != (by > py_r);
  assign dy  = {by[COORD_W-1], by}     - {ay[COORD_W-1], ay};
  assign dxp = {px_r[COORD_W-1], px_r} - {ax[COORD_W-1], ax};
  assign dxb = {bx[COORD_W-1], bx}     - {ax[COORD_W-1], ax};
  assign dyp = {py_r[COORD_W-1], py_r} - {ay[COORD_W-1], ay};
  assign lhs = dxp * dy;
  assign rhs = dxb * dyp;

  logic                 s2_straddle_r, s2_dyneg_r;
  logic signed [PW-1:0] s2_lhs_r, s2_rhs_r;

  always_ff @(posedge clk) begin
    if (rd_v_r) begin
      prev_x_r <= ax;
      prev_y_r <= ay;
    end
    s2_straddle_r <= straddle;
    s2_dyneg_r    <= dy[COORD_W];
    s2_lhs_r      <= lhs;
    s2_rhs_r      <= rhs;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: compare, flip sense when dy is negative, accumulate parity.
  // ---------------------------------------------------------------------------
  logic crossing, parity_nxt;

  assign crossing   = s2_straddle_r && (s2_dyneg_r ? (s2_lhs_r > s2_rhs_r)
                                                   : (s2_lhs_r < s2_rhs_r));
  assign parity_nxt = parity_r ^ (s2_v_r && crossing);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r      <= 1'b0;
      s2_last_r   <= 1'b0;
      parity_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s2_v_r      <= rd_v_r && !rd_first_r;
      s2_last_r   <= rd_last_r;
      out_valid_r <= 1'b0;
      if (req_qry) begin
        parity_r <= 1'b0;
      end else begin
        parity_r <= parity_nxt;
      end
      if (req_qry && short_poly) begin
        out_valid_r <= 1'b1;
      end else if (s2_v_r && s2_last_r) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_qry && short_poly) begin
      out_inside_r <= 1'b0;
    end else if (s2_v_r && s2_last_r) begin
      out_inside_r <= parity_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `PIP_ASSERT_NEXT(a_write_no_result, clk, rst_n, req_acc && (in_command == CMD_WRITE), !out_valid_r)
  `PIP_ASSERT_IMPLY(a_issue_bound, clk, rst_n, state_r == ST_RUN, iss_r <= n_r)
  `PIP_ASSERT_IMPLY(a_edge_in_pass, clk, rst_n, s2_v_r, state_r != ST_IDLE)

endmodule

// File: tb/sv/point_in_polygon_test_check.sv
// Checker for the point-in-polygon block: mirrors the vertex store, predicts each answer, compares.
module point_in_polygon_test_check #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic                               busy,
  input  logic                               in_command,
  input  logic        [pip_pkg::IDX_W-1:0]   in_vertex_index,
  input  logic signed [pip_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [pip_pkg::COORD_W-1:0] in_coord_y,
  input  logic                               out_valid,
  input  logic                               out_inside_res,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic        [pip_pkg::CNT_W-1:0]   cfg_vertex_count,
  output int                                 mismatches,
  output int                                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import pip_pkg::*;

  typedef struct {
    logic                      in_poly;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
  } query_outcome_t;

  logic signed [COORD_W-1:0] vert_x [MAX_VERTICES];
  logic signed [COORD_W-1:0] vert_y [MAX_VERTICES];
  logic        [CNT_W-1:0]   poly_count;
  query_outcome_t            outcomes_due [$];

  // Even-odd count of edges crossed by a ray from (px,py) towards +x.
  // Cross-multiplied form of the intersection test; sense flips with dy.
  function automatic logic ray_parity(input longint px, input longint py);
    longint ax, ay, bx, by, dy, lhs, rhs;
    int     n, j;
    logic   odd;
    n   = (poly_count > MAX_VERTICES) ? MAX_VERTICES : int'(poly_count);
    odd = 1'b0;
    if (n < MIN_POLY_VERTICES) return 1'b0;
    j = n - 1;
    for (int i = 0; i < n; i++) begin
      ax = vert_x[i];
      ay = vert_y[i];
      bx = vert_x[j];
      by = vert_y[j];
      if ((ay > py) != (by > py)) begin
        dy  = by - ay;
        lhs = (px - ax) * dy;
        rhs = (bx - ax) * (py - ay);
        if ((dy > 0) ? (lhs < rhs) : (lhs > rhs)) odd = ~odd;
      end
      j = i;
    end
    return odd;
  endfunction

  task automatic note_miss(input string what);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] %s", $time, what);
  endtask

  always @(posedge clk) begin : watch
    query_outcome_t due;
    if (!rst_n) begin
      poly_count = '0;
      outcomes_due.delete();
    end else begin
      // a result can never belong to a request taken at the same edge
      if (out_valid) begin
        if (outcomes_due.size() == 0) begin
          note_miss($sformatf("inside_res %0d with no query outstanding", out_inside_res));
        end else begin
          due = outcomes_due.pop_front();
          if (out_inside_res !== due.in_poly)
            note_miss($sformatf("inside_res for point (%0d,%0d): expected %0d, got %0b",
                                due.px, due.py, due.in_poly, out_inside_res));
        end
      end
      if (start && !busy) begin
        if (in_command == CMD_WRITE) begin
          if (in_vertex_index < MAX_VERTICES) begin
            vert_x[in_vertex_index] = in_coord_x;
            vert_y[in_vertex_index] = in_coord_y;
          end
        end else begin
          due.in_poly = ray_parity(in_coord_x, in_coord_y);
          due.px      = in_coord_x;
          due.py      = in_coord_y;
          outcomes_due.insert(outcomes_due.size(), due);
        end
      end
      // a request taken at this edge still sees the old count
      if (cfg_valid && cfg_ready) poly_count = cfg_vertex_count;
    end
    pending = outcomes_due.size();
  end

endmodule

// File: tb/sv/point_in_polygon_test_test.sv
// Testbench top for the point-in-polygon block: clock, reset, requests and the verdict.
module point_in_polygon_test_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pip_pkg::*;

  localparam int MAX_VERTICES  = 64;
  localparam int ITEM_TARGET   = 1450;
  // slowest run: ~1500 requests, many of them full-memory queries, plus long sender gaps
  localparam int CYCLE_LIMIT   = 600000;
  // settle time, longer than a full 64-vertex query takes from acceptance to its answer
  localparam int SETTLE_CYCLES = 80;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic                      in_command;
  logic        [IDX_W-1:0]   in_vertex_index;
  logic signed [COORD_W-1:0] in_coord_x;
  logic signed [COORD_W-1:0] in_coord_y;
  logic                      out_valid;
  logic                      out_inside_res;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic        [CNT_W-1:0]   cfg_vertex_count;
  int                        mismatches;
  int                        pending;

  // stimulus-side copy of the polygon, only used to aim query points
  bit signed [COORD_W-1:0] poly_x [MAX_VERTICES];
  bit signed [COORD_W-1:0] poly_y [MAX_VERTICES];
  int                      idle_pct;
  int                      sent;
  int                      cycle_cnt;

  point_in_polygon_test #(
    .MAX_VERTICES(MAX_VERTICES)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_vertex_index (in_vertex_index),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .out_valid       (out_valid),
    .out_inside_res  (out_inside_res),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_vertex_count(cfg_vertex_count)
  );

  point_in_polygon_test_check #(
    .MAX_VERTICES(MAX_VERTICES)
  ) chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_vertex_index (in_vertex_index),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .out_valid       (out_valid),
    .out_inside_res  (out_inside_res),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_vertex_count(cfg_vertex_count),
    .mismatches      (mismatches),
    .pending         (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost answer ends the run here.
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("point_in_polygon_test: mismatch");
    $finish;
  end

  // Coordinate from a box of +/-span, or from the full 16-bit range (span 0),
  // with the two extremes picked often in the latter.
  function automatic logic signed [COORD_W-1:0] rand_coord(input int span);
    if (span == 0) begin
      case ($urandom_range(0, 7))
        0:       return 16'sh8000;
        1:       return 16'sh7fff;
        default: return COORD_W'($urandom);
      endcase
    end
    return COORD_W'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // One request. Called just after a falling edge; returns just after the
  // falling edge that follows acceptance, with start still high, so a
  // back-to-back request never lowers and raises start in the same step.
  task automatic issue(input logic cmd, input logic [IDX_W-1:0] idx,
                       input logic signed [COORD_W-1:0] x,
                       input logic signed [COORD_W-1:0] y);
    while ($urandom_range(0, 99) < idle_pct) begin
      start           <= 1'b0;
      in_command      <= 1'($urandom);
      in_vertex_index <= IDX_W'($urandom);
      in_coord_x      <= COORD_W'($urandom);
      in_coord_y      <= COORD_W'($urandom);
      @(negedge clk);
    end
    start           <= 1'b1;
    in_command      <= cmd;
    in_vertex_index <= idx;
    in_coord_x      <= x;
    in_coord_y      <= y;
    // busy only moves on a rising edge, so its value now holds at the next one
    while (busy) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic put_vertex(input logic [IDX_W-1:0] idx,
                            input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y);
    poly_x[idx] = x;
    poly_y[idx] = y;
    issue(CMD_WRITE, idx, x, y);
  endtask

  task automatic query(input logic signed [COORD_W-1:0] x,
                       input logic signed [COORD_W-1:0] y);
    // the slot field is don't-care on a query, so it carries noise
    issue(CMD_QUERY, IDX_W'($urandom), x, y);
  endtask

  // Register write only once the block is quiet: all answers in, a short
  // pause for a write request still in flight, then busy low.
  task automatic set_count(input logic [CNT_W-1:0] value);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    while (busy) @(negedge clk);
    cfg_valid        <= 1'b1;
    cfg_vertex_count <= value;
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
    cfg_valid        <= 1'b0;
    cfg_vertex_count <= CNT_W'($urandom);
  endtask

  // Query point aimed at the polygon: vertices, their neighbourhood and the
  // horizontal lines through them are where the half-open rule bites.
  task automatic query_near(input int nn, input int span);
    int                        v, w;
    logic signed [COORD_W-1:0] qx, qy;
    v = (nn > 0) ? $urandom_range(0, nn - 1) : 0;
    w = (nn > 0) ? $urandom_range(0, nn - 1) : 0;
    case ($urandom_range(0, 9))
      3: begin
        qx = poly_x[v];
        qy = poly_y[v];
      end
      4, 5: begin
        qx = poly_x[v] + COORD_W'(int'($urandom_range(0, 4)) - 2);
        qy = poly_y[v] + COORD_W'(int'($urandom_range(0, 4)) - 2);
      end
      6, 7: begin
        qx = rand_coord(span);
        qy = poly_y[v];
      end
      8: begin
        qx = rand_coord(0);
        qy = rand_coord(0);
      end
      9: begin
        qx = poly_x[v];
        qy = poly_y[w];
      end
      default: begin
        qx = rand_coord(span);
        qy = rand_coord(span);
      end
    endcase
    query(qx, qy);
  endtask

  initial begin : stimulus
    int idle_modes [4];
    int phase, r, span, body, nn, goal;
    logic [CNT_W-1:0] cnt;

    // every input known from time zero
    rst_n            = 1'b0;
    start            = 1'b0;
    in_command       = CMD_WRITE;
    in_vertex_index  = '0;
    in_coord_x       = '0;
    in_coord_y       = '0;
    cfg_valid        = 1'b0;
    cfg_vertex_count = '0;
    idle_pct         = 0;
    sent             = 0;
    // sender idle rates per phase; the receiver cannot stall, so its phase
    // runs with a busy sender
    idle_modes = '{0, 78, 0, 31};

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // --- directed part ---
    // full-range triangle, plus the top slot written once
    put_vertex(0, -32768, -32768);
    put_vertex(1, 32767, -32768);
    put_vertex(2, 0, 32767);
    put_vertex(63, 32767, 32767);
    // too few vertices: always outside
    set_count(0);
    query(0, 0);
    set_count(2);
    query(0, 0);
    set_count(3);
    query(0, 0);
    query(-32768, 32767);
    query(-32768, -32768);   // on a vertex
    query(0, -32768);        // on the bottom horizontal edge
    query(32767, 32767);
    // small square: points on horizontal edges, a corner and a vertical side
    put_vertex(0, 0, 0);
    put_vertex(1, 10, 0);
    put_vertex(2, 10, 10);
    put_vertex(3, 0, 10);
    set_count(4);
    query(5, 5);
    query(5, 0);
    query(5, 10);
    query(0, 0);
    query(10, 5);
    query(-1, 5);

    // --- random part: phases of one polygon each ---
    goal  = sent + ITEM_TARGET;
    phase = 0;
    while (sent < goal) begin
      idle_pct = idle_modes[phase % 4];
      r = $urandom_range(0, 99);
      if (phase == 0)   cnt = 7'd127;        // count above the store
      else if (phase == 1) cnt = 7'd64;
      else if (r < 8)   cnt = CNT_W'($urandom_range(0, 2));
      else if (r < 86)  cnt = CNT_W'($urandom_range(3, 10));
      else if (r < 93)  cnt = CNT_W'($urandom_range(11, 63));
      else if (r < 96)  cnt = 7'd64;
      else              cnt = CNT_W'($urandom_range(65, 127));
      nn = (cnt > MAX_VERTICES) ? MAX_VERTICES : int'(cnt);
      r = $urandom_range(0, 9);
      span = (r < 4) ? 8 : (r < 8) ? 1000 : 0;

      set_count(cnt);
      // well-formed sequence: every slot in use is written before any query
      for (int i = 0; i < nn; i++) put_vertex(IDX_W'(i), rand_coord(span), rand_coord(span));
      body = $urandom_range(15, 40);
      for (int b = 0; b < body; b++) begin
        if ($urandom_range(0, 3) == 0)
          put_vertex(IDX_W'($urandom_range(0, MAX_VERTICES - 1)),
                     rand_coord(span), rand_coord(span));
        else
          query_near(nn, span);
      end
      phase++;
    end

    // drain, then give any stray strobe time to show up
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("point_in_polygon_test: match");
    end else begin
      $display("point_in_polygon_test: mismatch");
    end
    $finish;
  end

endmodule
